// File: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared constants, result codes and sequencer types for the allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int DEF_PAGE_COUNT = 1024;
    localparam int DEF_TOP_ORDER  = 6;

    // Order code stored for a page that is not the head of any block.
    localparam logic [3:0] ORDER_NONE = 4'd15;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_ALLOCATED = 3'd0,
        STATUS_BAD_ORDER = 3'd1,
        STATUS_NO_SPACE  = 3'd2,
        STATUS_FREED     = 3'd3,
        STATUS_NOT_USED  = 3'd4
    } status_t;

    // Field updates applied by the read-modify-write step.
    typedef enum logic [1:0] {
        MOD_NEXT,
        MOD_PREV,
        MOD_PUSH,
        MOD_ORDER
    } mod_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SEARCH,
        S_A_UNL,
        S_A_SPLIT,
        S_PUSH,
        S_PUSH2,
        S_F_CHK,
        S_F_LOOP,
        S_F_BCHK,
        S_F_UN2,
        S_F_MRG,
        S_F_NEXT,
        S_F_FIN,
        S_DONE,
        S_RMW_RD,
        S_RMW_WR
    } state_t;

endpackage

// File: rtl/bpa_store.sv
// ----------------------------------------------------------------------------
// Buddy page allocator record store
// One write port and one read port with registered read data, holding the
// order, used mark and free-list links of every page.
// ----------------------------------------------------------------------------
module bpa_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int RW    = 27
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [RW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [RW-1:0] wr_data
);

    logic [RW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Binary buddy allocator over PAGE_COUNT pages with orders 0..TOP_ORDER.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: an allocate names an order, a free names
// the first page of a block. Each request produces exactly one response on
// the m_ stream carrying a status, a page and an order.
// All page records live in a single-port-write, registered-read store, and a
// small sequencer walks the free lists one record access at a time. Every
// link or order update through the RMW steps is a read followed by a write.
// An invalid order or out-of-range free answers without a store access. An
// allocate searches the lists upward from the requested order, then splits
// the block found down to that order, appending each spare buddy in range
// to its list. A free merges the block with its free buddy order by order,
// then appends the final block to its list.
// After reset the core sweeps the store once, one page per cycle, building
// the top-order free list; s_tready stays low meanwhile. A new request is
// taken while an earlier response still waits in the output register;
// when the receiver stalls, the finished response of the next request
// waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core #(
    parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
    parameter int TOP_ORDER  = bpa_pkg::DEF_TOP_ORDER
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // opcode[0], request_order[4:1], page_index[14:5], 0
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[2:0], result_page[12:3], result_order[16:13], 0
);

    import bpa_pkg::*;

    localparam int AW     = $clog2(PAGE_COUNT);
    localparam int LW     = AW + 1;             // link: nil flag above the index
    localparam int RW     = 2 * LW + 5;         // prev, next, used, order
    localparam int NLIST  = TOP_ORDER + 1;
    localparam int OW     = $clog2(NLIST);
    localparam int BS     = 1 << TOP_ORDER;
    localparam int NBLK   = PAGE_COUNT / BS;
    localparam int USED_B = 2 * LW;
    localparam int ORD_LO = 2 * LW + 1;

    localparam logic [LW-1:0] LINK_NIL = {1'b1, {AW{1'b0}}};
    localparam logic [3:0]    TOP4     = 4'(TOP_ORDER);

    function automatic logic [LW-1:0] mk_link(input int idx);
        mk_link = {1'b0, AW'(idx)};
    endfunction

    // Sequencer and datapath registers.
    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    state_t           push_ret_reg, push_ret_next;
    logic             op_reg, op_next;
    logic [3:0]       req_reg, req_next;
    logic [9:0]       inpg_reg, inpg_next;
    logic [AW-1:0]    p_reg, p_next;
    logic [AW-1:0]    x_reg, x_next;
    logic [3:0]       ord_reg, ord_next;
    logic [LW-1:0]    v_reg, v_next;
    logic [LW-1:0]    n_reg, n_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    rmw_addr_reg, rmw_addr_next;
    mod_t             rmw_mod_reg, rmw_mod_next;
    logic [LW-1:0]    rmw_link_reg, rmw_link_next;
    logic [3:0]       rmw_ord_reg, rmw_ord_next;
    status_t          res_status_reg, res_status_next;
    logic [9:0]       res_page_reg, res_page_next;
    logic [3:0]       res_order_reg, res_order_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [9:0]       out_page_reg, out_page_next;
    logic [3:0]       out_order_reg, out_order_next;
    logic [LW-1:0]    head_reg [NLIST];
    logic [LW-1:0]    head_next [NLIST];
    logic [LW-1:0]    tail_reg [NLIST];
    logic [LW-1:0]    tail_next [NLIST];

    // Record store ports.
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [RW-1:0]    mem_rdata;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [RW-1:0]    mem_wdata;

    // Fields of the record read in the previous cycle.
    logic [LW-1:0]    rd_prev, rd_next;
    logic             rd_used;
    logic [3:0]       rd_order;

    // Address arithmetic of the current step.
    logic [OW-1:0]    oi;
    logic [31:0]      p32, bit_cur, bit_split, buddy_free, buddy_split;
    logic             p_is_hi, buddy_is_hi;
    logic [3:0]       ord_up;
    logic [LW-1:0]    cur_head, cur_tail;
    logic             accept, out_load;

    // Reset image of the page being swept.
    int               ci;
    logic             c_head;

    assign rd_prev   = mem_rdata[LW-1:0];
    assign rd_next   = mem_rdata[2*LW-1:LW];
    assign rd_used   = mem_rdata[USED_B];
    assign rd_order  = mem_rdata[ORD_LO+3:ORD_LO];

    assign oi          = ord_reg[OW-1:0];
    assign p32         = 32'(p_reg);
    assign bit_cur     = 32'd1 << ord_reg;
    assign bit_split   = 32'd1 << (ord_reg - 4'd1);
    assign buddy_free  = p32 ^ bit_cur;
    assign buddy_split = p32 ^ bit_split;
    assign p_is_hi     = (p32 & bit_cur) != 32'd0;
    assign buddy_is_hi = !p_is_hi;
    assign ord_up      = ord_reg + 4'd1;
    assign cur_head    = head_reg[oi];
    assign cur_tail    = tail_reg[oi];

    assign ci     = int'(clr_reg);
    assign c_head = ((ci & (BS - 1)) == 0) && (ci + BS <= PAGE_COUNT);

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    bpa_store #(
        .DEPTH (PAGE_COUNT),
        .AW    (AW),
        .RW    (RW)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rdata),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wdata)
    );

    // Next state and register updates.
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        push_ret_next   = push_ret_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        inpg_next       = inpg_reg;
        p_next          = p_reg;
        x_next          = x_reg;
        ord_next        = ord_reg;
        v_next          = v_reg;
        n_next          = n_reg;
        clr_next        = clr_reg;
        rmw_addr_next   = rmw_addr_reg;
        rmw_mod_next    = rmw_mod_reg;
        rmw_link_next   = rmw_link_reg;
        rmw_ord_next    = rmw_ord_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_order_next  = res_order_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = s_tdata[0];
                    req_next   = s_tdata[4:1];
                    inpg_next  = s_tdata[14:5];
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_page_next  = 10'd0;
                res_order_next = 4'd0;
                if (op_reg == OP_ALLOC)
                begin
                    if (req_reg > TOP4)
                    begin
                        res_status_next = STATUS_BAD_ORDER;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ord_next   = req_reg;
                        state_next = S_SEARCH;
                    end
                end
                else if (32'(inpg_reg) >= PAGE_COUNT)
                begin
                    res_status_next = STATUS_NOT_USED;
                    res_page_next   = inpg_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    p_next     = AW'(32'(inpg_reg));
                    state_next = S_F_CHK;
                end
            end
            S_SEARCH:
            begin
                if (cur_head[AW])
                begin
                    if (ord_reg == TOP4)
                    begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ord_next = ord_up;
                    end
                end
                else
                begin
                    p_next     = cur_head[AW-1:0];
                    state_next = S_A_UNL;
                end
            end
            S_A_UNL:
            begin
                // The taken block is the list head, so only its successor
                // needs its back link cut.
                head_next[oi] = rd_next;
                if (rd_next[AW])
                begin
                    tail_next[oi] = LINK_NIL;
                    state_next    = S_A_SPLIT;
                end
                else
                begin
                    rmw_addr_next = rd_next[AW-1:0];
                    rmw_mod_next  = MOD_PREV;
                    rmw_link_next = LINK_NIL;
                    ret_next      = S_A_SPLIT;
                    state_next    = S_RMW_RD;
                end
            end
            S_A_SPLIT:
            begin
                if (ord_reg == req_reg)
                begin
                    res_status_next = STATUS_ALLOCATED;
                    res_page_next   = 10'(p32);
                    res_order_next  = req_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    ord_next = ord_reg - 4'd1;
                    if (buddy_split < PAGE_COUNT)
                    begin
                        x_next        = AW'(buddy_split);
                        push_ret_next = S_A_SPLIT;
                        state_next    = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                rmw_addr_next = x_reg;
                rmw_mod_next  = MOD_PUSH;
                rmw_link_next = cur_tail;
                rmw_ord_next  = ord_reg;
                ret_next      = S_PUSH2;
                state_next    = S_RMW_RD;
            end
            S_PUSH2:
            begin
                tail_next[oi] = {1'b0, x_reg};
                if (cur_tail[AW])
                begin
                    head_next[oi] = {1'b0, x_reg};
                    state_next    = push_ret_reg;
                end
                else
                begin
                    rmw_addr_next = cur_tail[AW-1:0];
                    rmw_mod_next  = MOD_NEXT;
                    rmw_link_next = {1'b0, x_reg};
                    ret_next      = push_ret_reg;
                    state_next    = S_RMW_RD;
                end
            end
            S_F_CHK:
            begin
                if (!rd_used || rd_order > TOP4)
                begin
                    res_status_next = STATUS_NOT_USED;
                    res_page_next   = inpg_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    ord_next   = rd_order;
                    state_next = S_F_LOOP;
                end
            end
            S_F_LOOP:
            begin
                if (ord_reg == TOP4 || buddy_free >= PAGE_COUNT)
                begin
                    x_next        = p_reg;
                    push_ret_next = S_F_FIN;
                    state_next    = S_PUSH;
                end
                else
                begin
                    state_next = S_F_BCHK;
                end
            end
            S_F_BCHK:
            begin
                if (rd_order != ord_reg || rd_used)
                begin
                    x_next        = p_reg;
                    push_ret_next = S_F_FIN;
                    state_next    = S_PUSH;
                end
                else
                begin
                    v_next = rd_prev;
                    n_next = rd_next;
                    if (rd_prev[AW])
                    begin
                        head_next[oi] = rd_next;
                        state_next    = S_F_UN2;
                    end
                    else
                    begin
                        rmw_addr_next = rd_prev[AW-1:0];
                        rmw_mod_next  = MOD_NEXT;
                        rmw_link_next = rd_next;
                        ret_next      = S_F_UN2;
                        state_next    = S_RMW_RD;
                    end
                end
            end
            S_F_UN2:
            begin
                if (n_reg[AW])
                begin
                    tail_next[oi] = v_reg;
                    state_next    = S_F_MRG;
                end
                else
                begin
                    rmw_addr_next = n_reg[AW-1:0];
                    rmw_mod_next  = MOD_PREV;
                    rmw_link_next = v_reg;
                    ret_next      = S_F_MRG;
                    state_next    = S_RMW_RD;
                end
            end
            S_F_MRG:
            begin
                rmw_addr_next = p_reg;
                rmw_mod_next  = MOD_ORDER;
                rmw_ord_next  = p_is_hi ? ORDER_NONE : ord_up;
                ret_next      = S_F_NEXT;
                state_next    = S_RMW_RD;
            end
            S_F_NEXT:
            begin
                p_next     = AW'(p32 & ~bit_cur);
                ord_next   = ord_up;
                state_next = S_F_LOOP;
            end
            S_F_FIN:
            begin
                res_status_next = STATUS_FREED;
                res_page_next   = 10'(p32);
                res_order_next  = ord_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RMW_RD:
            begin
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                state_next = ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register of the response stream.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_order_next  = out_order_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_page_next   = res_page_reg;
            out_order_next  = res_order_reg;
        end
    end

    // Record store accesses and handshake outputs.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = p_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = p_reg;
        mem_wdata   = mem_rdata;
        s_tready    = (state_reg == S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wdata   = {ORDER_NONE, 1'b0, LINK_NIL, LINK_NIL};
                if (c_head)
                begin
                    mem_wdata[ORD_LO+3:ORD_LO] = TOP4;
                    if (ci + 2 * BS <= PAGE_COUNT)
                    begin
                        mem_wdata[2*LW-1:LW] = mk_link(ci + BS);
                    end
                    if (ci >= BS)
                    begin
                        mem_wdata[LW-1:0] = mk_link(ci - BS);
                    end
                end
            end
            S_START:
            begin
                mem_rd_en   = (op_reg == OP_FREE) && (32'(inpg_reg) < PAGE_COUNT);
                mem_rd_addr = AW'(32'(inpg_reg));
            end
            S_SEARCH:
            begin
                mem_rd_en   = !cur_head[AW];
                mem_rd_addr = cur_head[AW-1:0];
            end
            S_A_UNL:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = p_reg;
                mem_wdata   = {req_reg, 1'b1, LINK_NIL, LINK_NIL};
            end
            S_F_CHK:
            begin
                mem_wr_en         = rd_used && (rd_order <= TOP4);
                mem_wr_addr       = p_reg;
                mem_wdata[USED_B] = 1'b0;
            end
            S_F_LOOP:
            begin
                mem_rd_en   = (ord_reg != TOP4) && (buddy_free < PAGE_COUNT);
                mem_rd_addr = AW'(buddy_free);
            end
            S_F_BCHK:
            begin
                mem_wr_en                  = (rd_order == ord_reg) && !rd_used;
                mem_wr_addr                = AW'(buddy_free);
                mem_wdata[2*LW-1:0]        = {LINK_NIL, LINK_NIL};
                mem_wdata[ORD_LO+3:ORD_LO] = buddy_is_hi ? ORDER_NONE : ord_up;
            end
            S_RMW_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = rmw_addr_reg;
            end
            S_RMW_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = rmw_addr_reg;
                case (rmw_mod_reg)
                    MOD_NEXT:
                    begin
                        mem_wdata[2*LW-1:LW] = rmw_link_reg;
                    end
                    MOD_PREV:
                    begin
                        mem_wdata[LW-1:0] = rmw_link_reg;
                    end
                    MOD_PUSH:
                    begin
                        mem_wdata[ORD_LO+3:ORD_LO] = rmw_ord_reg;
                        mem_wdata[2*LW-1:0]        = {LINK_NIL, rmw_link_reg};
                    end
                    MOD_ORDER:
                    begin
                        mem_wdata[ORD_LO+3:ORD_LO] = rmw_ord_reg;
                    end
                    default:
                    begin
                        mem_wdata = mem_rdata;
                    end
                endcase
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_order_reg, out_page_reg, out_status_reg};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NLIST; k++)
            begin
                if (k == TOP_ORDER && NBLK > 0)
                begin
                    head_reg[k] <= mk_link(0);
                    tail_reg[k] <= mk_link((NBLK - 1) * BS);
                end
                else
                begin
                    head_reg[k] <= LINK_NIL;
                    tail_reg[k] <= LINK_NIL;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ret_reg        <= ret_next;
        push_ret_reg   <= push_ret_next;
        op_reg         <= op_next;
        req_reg        <= req_next;
        inpg_reg       <= inpg_next;
        p_reg          <= p_next;
        x_reg          <= x_next;
        ord_reg        <= ord_next;
        v_reg          <= v_next;
        n_reg          <= n_next;
        rmw_addr_reg   <= rmw_addr_next;
        rmw_mod_reg    <= rmw_mod_next;
        rmw_link_reg   <= rmw_link_next;
        rmw_ord_reg    <= rmw_ord_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_order_reg  <= res_order_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_order_reg  <= out_order_next;
    end

    // A write step always follows its own read step.
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RMW_WR |-> $past(state_reg) == S_RMW_RD)
        else $error("record write without preceding read");

    // An accepted request starts the sequencer on the next cycle.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_START)
        else $error("request accepted but sequencer did not start");

    // An allocated block never exceeds the top order.
    a_alloc_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_ALLOCATED |-> out_order_reg <= TOP4)
        else $error("allocated order above top order");

    // The store is untouched while waiting for a request.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_rd_en && !mem_wr_en)
        else $error("record store accessed while idle");

endmodule
